### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fthp_pkg.sv
package fthp_pkg;

  localparam int TICK_BITS_DEF = 8;

  localparam int CFG_ADDR_BITS = 4;

  typedef enum logic [1:0] {
    REG_SHIFT_MODE = 2'd0,
    REG_HOLD       = 2'd1,
    REG_TAP        = 2'd2,
    REG_HEARTBEAT  = 2'd3
  } reg_idx_t;

  localparam logic       SHIFT_MOMENTARY_RST = 1'b0;
  localparam logic [7:0] HOLD_TICKS_RST      = 8'd94;
  localparam logic [7:0] TAP_TICKS_RST       = 8'd29;
  localparam logic [7:0] HEARTBEAT_TICKS_RST = 8'd47;

  // Blink lengths in ticks
  localparam logic [5:0] BLINK_CLEAR = 6'd40;
  localparam logic [5:0] BLINK_RESET = 6'd40;
  localparam logic [4:0] BLINK_PAGE3 = 5'd25;

  localparam int CLEAR_STATUS_DIV = 6;
  localparam int RESET_STATUS_DIV = 9;
  localparam int RESET_LED_DIV    = 5;

  typedef struct packed {
    logic       shift_momentary;
    logic [7:0] hold_ticks;
    logic [7:0] tap_ticks;
    logic [7:0] heartbeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic shift_switch;
    logic source_switch;
    logic bypass_footswitch;
    logic record_footswitch;
    logic engine_recording;
  } in_item_t;

  typedef struct packed {
    logic shift_active;
    logic page3_active;
    logic bypass_on;
    logic record_on;
    logic lfo_enable;
    logic reset_params_pulse;
    logic clear_buffer_pulse;
    logic engaged_led;
    logic status_led;
    logic heartbeat_led;
    logic shift_led_red;
    logic shift_led_green;
  } out_item_t;

  // Blink phase tables, one bit per blink count value
  function automatic logic [63:0] clear_status_mask();
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) m[i] = 1'((i / CLEAR_STATUS_DIV) & 1);
    return m;
  endfunction

  function automatic logic [63:0] reset_status_mask();
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) m[i] = 1'((i / RESET_STATUS_DIV) & 1);
    return m;
  endfunction

  function automatic logic [63:0] reset_led_mask();
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) m[i] = 1'((i / RESET_LED_DIV) & 1);
    return m;
  endfunction

  localparam logic [63:0] CLEAR_STATUS_MASK = clear_status_mask();
  localparam logic [63:0] RESET_STATUS_MASK = reset_status_mask();
  localparam logic [63:0] RESET_LED_MASK    = reset_led_mask();

endpackage

### rtl/fthp_if.sv
interface fthp_sample_if;
  logic               valid;
  logic               ready;
  fthp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fthp_result_if;
  logic                valid;
  logic                ready;
  fthp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/fthp_core.sv
module fthp_core #(
  parameter int TICK_BITS = fthp_pkg::TICK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  fthp_pkg::cfg_t      cfg,
  input  fthp_pkg::in_item_t  item,
  output fthp_pkg::out_item_t result
);

  localparam int CmpBits = (TICK_BITS > 8) ? TICK_BITS : 8;

  logic                 shift_latch_bit, shift_latch_bit_next;
  logic                 shift_button_down, shift_button_down_next;
  logic                 shift_button_held, shift_button_held_next;
  logic [TICK_BITS-1:0] shift_press_ticks, shift_press_ticks_next;
  logic                 bypass_down, bypass_down_next;
  logic                 bypass_consumed, bypass_consumed_next;
  logic [TICK_BITS-1:0] bypass_press_ticks, bypass_press_ticks_next;
  logic                 record_down, record_down_next;
  logic                 record_consumed, record_consumed_next;
  logic [TICK_BITS-1:0] record_press_ticks, record_press_ticks_next;
  logic                 bypass_state, bypass_state_next;
  logic                 recording_state, recording_state_next;
  logic                 lfo_state, lfo_state_next;
  logic                 source_prev, source_prev_next;
  logic                 page3_prev, page3_prev_next;
  logic [5:0]           clear_blink_count, clear_blink_count_next;
  logic [5:0]           reset_blink_count, reset_blink_count_next;
  logic [4:0]           page3_blink_count, page3_blink_count_next;
  logic [7:0]           heartbeat_count, heartbeat_count_next;
  logic                 heartbeat_state, heartbeat_state_next;

  function automatic logic [TICK_BITS-1:0] tick_up(input logic [TICK_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic reached(input logic [TICK_BITS-1:0] c, input logic [7:0] thr);
    return CmpBits'(c) >= CmpBits'(thr);
  endfunction

  function automatic logic reset_led_bit(input logic [5:0] c);
    return fthp_pkg::RESET_LED_MASK[c];
  endfunction

  always_comb begin
    shift_latch_bit_next    = shift_latch_bit;
    shift_button_down_next  = shift_button_down;
    shift_button_held_next  = shift_button_held;
    shift_press_ticks_next  = shift_press_ticks;
    bypass_down_next        = bypass_down;
    bypass_consumed_next    = bypass_consumed;
    bypass_press_ticks_next = bypass_press_ticks;
    record_down_next        = record_down;
    record_consumed_next    = record_consumed;
    record_press_ticks_next = record_press_ticks;
    bypass_state_next       = bypass_state;
    recording_state_next    = recording_state;
    lfo_state_next          = lfo_state;
    source_prev_next        = source_prev;
    clear_blink_count_next  = clear_blink_count;
    reset_blink_count_next  = reset_blink_count;
    page3_blink_count_next  = page3_blink_count;
    result                  = '0;

    // Shift page: momentary button with tap/hold, or plain toggle switch
    if (cfg.shift_momentary) begin
      if (item.shift_switch) begin
        if (!shift_button_down) begin
          shift_button_down_next = 1'b1;
          shift_press_ticks_next = '0;
          shift_button_held_next = 1'b0;
        end
        shift_press_ticks_next = tick_up(shift_press_ticks_next);
        if (!shift_button_held_next && reached(shift_press_ticks_next, cfg.tap_ticks)) begin
          shift_button_held_next = 1'b1;
        end
      end else if (shift_button_down) begin
        shift_button_down_next = 1'b0;
        if (!shift_button_held) shift_latch_bit_next = ~shift_latch_bit;
        shift_button_held_next = 1'b0;
      end
      result.shift_active = shift_latch_bit_next;
      result.page3_active = shift_button_held_next;
      if (reset_blink_count != '0) begin
        result.shift_led_red   = reset_led_bit(reset_blink_count);
        result.shift_led_green = reset_led_bit(reset_blink_count);
      end else begin
        result.shift_led_red   = shift_button_held_next;
        result.shift_led_green = shift_latch_bit_next & ~shift_button_held_next;
      end
    end else begin
      result.shift_active = item.shift_switch;
      result.page3_active = item.shift_switch & item.bypass_footswitch;
    end

    // Bypass footswitch: tap toggles bypass, hold requests parameter reset
    if (result.page3_active) begin
      bypass_down_next        = 1'b0;
      bypass_consumed_next    = 1'b0;
      bypass_press_ticks_next = '0;
    end else if (item.bypass_footswitch) begin
      if (!bypass_down) begin
        bypass_down_next        = 1'b1;
        bypass_press_ticks_next = '0;
        bypass_consumed_next    = 1'b0;
      end
      bypass_press_ticks_next = tick_up(bypass_press_ticks_next);
      if (!bypass_consumed_next && reached(bypass_press_ticks_next, cfg.hold_ticks)) begin
        result.reset_params_pulse = 1'b1;
        bypass_consumed_next      = 1'b1;
        reset_blink_count_next    = fthp_pkg::BLINK_RESET;
      end
    end else if (bypass_down) begin
      bypass_down_next = 1'b0;
      if (!bypass_consumed) bypass_state_next = ~bypass_state;
    end

    // Record footswitch: tap toggles record, hold clears the buffer and stops
    if (item.record_footswitch) begin
      if (!record_down) begin
        record_down_next        = 1'b1;
        record_press_ticks_next = '0;
        record_consumed_next    = 1'b0;
      end
      record_press_ticks_next = tick_up(record_press_ticks_next);
      if (!record_consumed_next && reached(record_press_ticks_next, cfg.hold_ticks)) begin
        result.clear_buffer_pulse = 1'b1;
        recording_state_next      = 1'b0;
        record_consumed_next      = 1'b1;
        clear_blink_count_next    = fthp_pkg::BLINK_CLEAR;
      end
    end else if (record_down) begin
      record_down_next = 1'b0;
      if (!record_consumed) recording_state_next = ~recording_state;
    end

    // Page 3: sample the source switch on entry, toggle LFO on each flip after
    if (result.page3_active) begin
      if (!page3_prev) begin
        source_prev_next = item.source_switch;
      end else if (item.source_switch != source_prev) begin
        lfo_state_next         = ~lfo_state;
        source_prev_next       = item.source_switch;
        page3_blink_count_next = fthp_pkg::BLINK_PAGE3;
      end
    end
    page3_prev_next = result.page3_active;

    // Engine auto stop lands after the record latch is reported
    result.record_on = recording_state_next;
    if (recording_state_next && !item.engine_recording) recording_state_next = 1'b0;

    heartbeat_count_next = heartbeat_count + 8'd1;
    heartbeat_state_next = heartbeat_state;
    if (heartbeat_count_next >= cfg.heartbeat_ticks) begin
      heartbeat_count_next = '0;
      heartbeat_state_next = ~heartbeat_state;
    end

    // Status LED blink chain, highest priority first
    if (clear_blink_count_next != '0) begin
      result.status_led      = fthp_pkg::CLEAR_STATUS_MASK[clear_blink_count_next];
      clear_blink_count_next = clear_blink_count_next - 6'd1;
    end else if (reset_blink_count_next != '0) begin
      result.status_led      = fthp_pkg::RESET_STATUS_MASK[reset_blink_count_next];
      reset_blink_count_next = reset_blink_count_next - 6'd1;
    end else if (page3_blink_count_next != '0) begin
      result.status_led      = page3_blink_count_next[2];
      page3_blink_count_next = page3_blink_count_next - 5'd1;
    end else begin
      result.status_led = recording_state_next;
    end

    result.bypass_on     = bypass_state_next;
    result.engaged_led   = ~bypass_state_next;
    result.lfo_enable    = lfo_state_next;
    result.heartbeat_led = heartbeat_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_latch_bit    <= 1'b0;
      shift_button_down  <= 1'b0;
      shift_button_held  <= 1'b0;
      shift_press_ticks  <= '0;
      bypass_down        <= 1'b0;
      bypass_consumed    <= 1'b0;
      bypass_press_ticks <= '0;
      record_down        <= 1'b0;
      record_consumed    <= 1'b0;
      record_press_ticks <= '0;
      bypass_state       <= 1'b1;
      recording_state    <= 1'b0;
      lfo_state          <= 1'b0;
      source_prev        <= 1'b0;
      page3_prev         <= 1'b0;
      clear_blink_count  <= '0;
      reset_blink_count  <= '0;
      page3_blink_count  <= '0;
      heartbeat_count    <= '0;
      heartbeat_state    <= 1'b0;
    end else if (advance) begin
      shift_latch_bit    <= shift_latch_bit_next;
      shift_button_down  <= shift_button_down_next;
      shift_button_held  <= shift_button_held_next;
      shift_press_ticks  <= shift_press_ticks_next;
      bypass_down        <= bypass_down_next;
      bypass_consumed    <= bypass_consumed_next;
      bypass_press_ticks <= bypass_press_ticks_next;
      record_down        <= record_down_next;
      record_consumed    <= record_consumed_next;
      record_press_ticks <= record_press_ticks_next;
      bypass_state       <= bypass_state_next;
      recording_state    <= recording_state_next;
      lfo_state          <= lfo_state_next;
      source_prev        <= source_prev_next;
      page3_prev         <= page3_prev_next;
      clear_blink_count  <= clear_blink_count_next;
      reset_blink_count  <= reset_blink_count_next;
      page3_blink_count  <= page3_blink_count_next;
      heartbeat_count    <= heartbeat_count_next;
      heartbeat_state    <= heartbeat_state_next;
    end
  end

endmodule

### rtl/footswitch_tap_hold_panel_unit.sv
// Footswitch tap/hold control panel. One sample item per audio block tick
// carries the debounced switch levels and the engine's record status; one
// result item comes back per sample with the page, bypass, record and LFO
// latches, the one-tick reset and clear requests, and all LED levels. The
// block takes one item per clock while the result is not stalled: the item is
// registered at the input, the whole tick update runs as combinational logic
// against the state registers, and the result is registered at the output, so
// a result is offered once its item moves from the input register into the
// output register, and a stalled result holds only the output register while
// the next item waits in the input register. Thresholds and the heartbeat
// period are set over the APB port (shift mode at 0x0, hold at 0x4, tap at
// 0x8, heartbeat at 0xC); write them only while no item is in flight.
module footswitch_tap_hold_panel_unit #(
  parameter int TICK_BITS = fthp_pkg::TICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  fthp_sample_if.sink                         sample,
  fthp_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fthp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  `include "assert_macros.svh"

  fthp_pkg::cfg_t      cfg;
  fthp_pkg::reg_idx_t  reg_idx;
  logic                in_valid;
  fthp_pkg::in_item_t  in_item;
  logic                out_valid;
  fthp_pkg::out_item_t out_item;
  fthp_pkg::out_item_t core_result;
  logic                advance;

  assign reg_idx = fthp_pkg::reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_momentary <= fthp_pkg::SHIFT_MOMENTARY_RST;
      cfg.hold_ticks      <= fthp_pkg::HOLD_TICKS_RST;
      cfg.tap_ticks       <= fthp_pkg::TAP_TICKS_RST;
      cfg.heartbeat_ticks <= fthp_pkg::HEARTBEAT_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        fthp_pkg::REG_SHIFT_MODE: cfg.shift_momentary <= pwdata[0];
        fthp_pkg::REG_HOLD:       cfg.hold_ticks      <= pwdata[7:0];
        fthp_pkg::REG_TAP:        cfg.tap_ticks       <= pwdata[7:0];
        fthp_pkg::REG_HEARTBEAT:  cfg.heartbeat_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fthp_pkg::REG_SHIFT_MODE: prdata = {31'd0, cfg.shift_momentary};
      fthp_pkg::REG_HOLD:       prdata = {24'd0, cfg.hold_ticks};
      fthp_pkg::REG_TAP:        prdata = {24'd0, cfg.tap_ticks};
      fthp_pkg::REG_HEARTBEAT:  prdata = {24'd0, cfg.heartbeat_ticks};
      default:                  prdata = '0;
    endcase
  end

  // Move the held item into the result register whenever that slot frees up
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) in_item <= sample.data;
  end

  fthp_core #(
    .TICK_BITS(TICK_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_item),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= core_result;
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

  `ASSERT_IMPL(a_clear_stops_record,
      out_valid && out_item.clear_buffer_pulse, !out_item.record_on,
      "buffer clear reported with record latch still set")
  `ASSERT_IMPL(a_toggle_mode_leds_dark,
      out_valid && !cfg.shift_momentary,
      !out_item.shift_led_red && !out_item.shift_led_green,
      "shift LEDs lit in toggle mode")
  `ASSERT_IMPL(a_reset_not_on_page3,
      out_valid && out_item.reset_params_pulse, !out_item.page3_active,
      "parameter reset issued while page 3 active")
  `ASSERT_NEXT(a_advance_fills_output,
      advance, out_valid,
      "result register empty after an item advanced")

endmodule

### tb/sv/fthp_panel_checker.sv
module fthp_panel_checker
  import fthp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  fthp_sample_if                   sample,
  fthp_result_if                   result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  input  logic                     pready,
  input  logic                     run_done,
  output int                       mismatches,
  output int                       pending,
  output int                       results_checked,
  output int                       hold_pulses
);

  localparam int TICK_BITS = TICK_BITS_DEF;

  string field_name [0:11] = '{"shift_active", "page3_active", "bypass_on", "record_on",
                               "lfo_enable", "reset_params_pulse", "clear_buffer_pulse",
                               "engaged_led", "status_led", "heartbeat_led",
                               "shift_led_red", "shift_led_green"};

  cfg_t                 cfg;
  logic                 sh_latch, sh_down, sh_held;
  logic [TICK_BITS-1:0] sh_cnt;
  logic                 bp_down, bp_used;
  logic [TICK_BITS-1:0] bp_cnt;
  logic                 rec_down, rec_used;
  logic [TICK_BITS-1:0] rec_cnt;
  logic                 bypassed, rec_latch, lfo, src_last, page3_was;
  logic [5:0]           clr_blink, rst_blink;
  logic [4:0]           page3_flash;
  logic [7:0]           hb_cnt;
  logic                 hb;
  out_item_t            tick_expect_q [$];
  bit                   leftovers_done;

  task automatic report(input string msg);
    if (mismatches < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic blink_phase(input int count, input int div);
    return ((count / div) % 2) != 0;
  endfunction

  // Advance the panel by one tick and return the result it should produce.
  function automatic out_item_t panel_tick(input in_item_t s);
    out_item_t o;
    logic      page3;
    o = '0;
    if (cfg.shift_momentary) begin
      if (s.shift_switch) begin
        if (!sh_down) begin
          sh_down = 1'b1;
          sh_cnt  = '0;
          sh_held = 1'b0;
        end
        if (sh_cnt != '1) sh_cnt++;
        if (!sh_held && sh_cnt >= cfg.tap_ticks) sh_held = 1'b1;
      end else if (sh_down) begin
        sh_down = 1'b0;
        if (!sh_held) sh_latch = ~sh_latch;
        sh_held = 1'b0;
      end
      o.shift_active = sh_latch;
      page3 = sh_held;
      // reset blink overrides the button LEDs while it runs
      if (rst_blink != 0) begin
        o.shift_led_red   = blink_phase(rst_blink, 5);
        o.shift_led_green = o.shift_led_red;
      end else begin
        o.shift_led_red   = sh_held;
        o.shift_led_green = sh_latch & ~sh_held;
      end
    end else begin
      o.shift_active = s.shift_switch;
      page3 = s.shift_switch & s.bypass_footswitch;
    end

    if (page3) begin
      bp_down = 1'b0;
      bp_used = 1'b0;
      bp_cnt  = '0;
    end else if (s.bypass_footswitch) begin
      if (!bp_down) begin
        bp_down = 1'b1;
        bp_cnt  = '0;
        bp_used = 1'b0;
      end
      if (bp_cnt != '1) bp_cnt++;
      if (!bp_used && bp_cnt >= cfg.hold_ticks) begin
        o.reset_params_pulse = 1'b1;
        bp_used   = 1'b1;
        rst_blink = BLINK_RESET;
      end
    end else if (bp_down) begin
      bp_down = 1'b0;
      if (!bp_used) bypassed = ~bypassed;
    end

    if (s.record_footswitch) begin
      if (!rec_down) begin
        rec_down = 1'b1;
        rec_cnt  = '0;
        rec_used = 1'b0;
      end
      if (rec_cnt != '1) rec_cnt++;
      if (!rec_used && rec_cnt >= cfg.hold_ticks) begin
        o.clear_buffer_pulse = 1'b1;
        rec_latch = 1'b0;
        rec_used  = 1'b1;
        clr_blink = BLINK_CLEAR;
      end
    end else if (rec_down) begin
      rec_down = 1'b0;
      if (!rec_used) rec_latch = ~rec_latch;
    end

    if (page3) begin
      if (!page3_was) begin
        src_last = s.source_switch;
      end else if (s.source_switch != src_last) begin
        lfo         = ~lfo;
        src_last    = s.source_switch;
        page3_flash = BLINK_PAGE3;
      end
    end
    page3_was = page3;

    o.record_on = rec_latch;
    // auto stop once the engine reports it is no longer recording
    if (rec_latch && !s.engine_recording) rec_latch = 1'b0;

    hb_cnt = hb_cnt + 8'd1;
    if (hb_cnt >= cfg.heartbeat_ticks) begin
      hb_cnt = '0;
      hb     = ~hb;
    end

    if (clr_blink != 0) begin
      o.status_led = blink_phase(clr_blink, 6);
      clr_blink--;
    end else if (rst_blink != 0) begin
      o.status_led = blink_phase(rst_blink, 9);
      rst_blink--;
    end else if (page3_flash != 0) begin
      o.status_led = blink_phase(page3_flash, 4);
      page3_flash--;
    end else begin
      o.status_led = rec_latch;
    end

    o.page3_active  = page3;
    o.bypass_on     = bypassed;
    o.lfo_enable    = lfo;
    o.engaged_led   = ~bypassed;
    o.heartbeat_led = hb;
    return o;
  endfunction

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    hold_pulses     = 0;
    leftovers_done  = 1'b0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cfg         = '{SHIFT_MOMENTARY_RST, HOLD_TICKS_RST, TAP_TICKS_RST, HEARTBEAT_TICKS_RST};
      sh_latch    = 1'b0;
      sh_down     = 1'b0;
      sh_held     = 1'b0;
      sh_cnt      = '0;
      bp_down     = 1'b0;
      bp_used     = 1'b0;
      bp_cnt      = '0;
      rec_down    = 1'b0;
      rec_used    = 1'b0;
      rec_cnt     = '0;
      bypassed    = 1'b1;
      rec_latch   = 1'b0;
      lfo         = 1'b0;
      src_last    = 1'b0;
      page3_was   = 1'b0;
      clr_blink   = '0;
      rst_blink   = '0;
      page3_flash = '0;
      hb_cnt      = '0;
      hb          = 1'b0;
      tick_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SHIFT_MODE: cfg.shift_momentary = pwdata[0];
          REG_HOLD:       cfg.hold_ticks      = pwdata[7:0];
          REG_TAP:        cfg.tap_ticks       = pwdata[7:0];
          REG_HEARTBEAT:  cfg.heartbeat_ticks = pwdata[7:0];
          default: ;
        endcase
      end
      // compare before queuing, so a result never matches an item taken at the same edge
      if (result.valid && result.ready) begin
        if (tick_expect_q.size() == 0) begin
          report($sformatf("result %b with no tick outstanding", result.data));
        end else begin
          want = tick_expect_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (result.data[11-i] !== want[11-i])
              report($sformatf("result %0d field %s: got %b, want %b", results_checked,
                               field_name[i], result.data[11-i], want[11-i]));
          end
        end
        results_checked++;
      end
      if (sample.valid && sample.ready) begin
        want = panel_tick(sample.data);
        if (want.reset_params_pulse || want.clear_buffer_pulse) hold_pulses++;
        tick_expect_q.push_back(want);
      end
      if (run_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (tick_expect_q.size() != 0)
          report($sformatf("%0d results never arrived", tick_expect_q.size()));
      end
    end
    pending = tick_expect_q.size();
  end

endmodule

### tb/sv/footswitch_tap_hold_panel_unit_tb.sv
module footswitch_tap_hold_panel_unit_tb;
  import fthp_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel, penable, pwrite, pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata, prdata;
  logic                     run_done;
  int                       mismatches, pending, results_checked, hold_pulses;
  int                       burst_left, items_sent, settings_used;
  logic [9:0]               stall_clk = '0;
  logic [3:0]               lv;
  int                       run_left [4];

  fthp_sample_if sample_ch ();
  fthp_result_if result_ch ();

  footswitch_tap_hold_panel_unit dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fthp_panel_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample_ch),
    .result          (result_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .run_done        (run_done),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .hold_pulses     (hold_pulses)
  );

  always #5 clk = ~clk;

  // receiver: cycle through always-ready, random and periodic stall stretches
  always @(negedge clk) begin
    stall_clk <= stall_clk + 10'd1;
    case (stall_clk[8:7])
      2'd0: result_ch.ready <= 1'b1;
      2'd1: result_ch.ready <= ($urandom_range(0, 9) < 7);
      2'd2: result_ch.ready <= (stall_clk[2:0] < 3'd5);
      default: result_ch.ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  initial begin
    #2_000_000;
    $display("footswitch_tap_hold_panel_unit_tb failed");
    $finish;
  end

  function automatic in_item_t mk(input logic sh, input logic src, input logic bp,
                                  input logic rec, input logic eng);
    in_item_t it;
    it.shift_switch      = sh;
    it.source_switch     = src;
    it.bypass_footswitch = bp;
    it.record_footswitch = rec;
    it.engine_recording  = eng;
    return it;
  endfunction

  // Length of the next run of one switch level: tap, hold or short flicker.
  function automatic int press_len(input int thr);
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, thr > 1 ? thr - 1 : 1);
      1: return $urandom_range(thr > 0 ? thr : 1, thr + 6);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    sample_ch.data  <= it;
    sample_ch.valid <= 1'b1;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_level(input in_item_t it, input int n);
    repeat (n) send_item(it);
  endtask

  // Hold off until every queued result has come back.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic btn, input int hold, input int tap, input int beat);
    settle();
    write_reg(REG_SHIFT_MODE, 32'(btn));
    write_reg(REG_HOLD, 32'(hold));
    write_reg(REG_TAP, 32'(tap));
    write_reg(REG_HEARTBEAT, 32'(beat));
    @(negedge clk);
    settings_used++;
  endtask

  // Switch levels held for tap/hold-shaped runs, with a tenth of raw noise.
  task automatic random_phase(input int n, input int hold_thr, input int tap_thr,
                              input bit drain_mid);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      if (drain_mid && i == n / 2) settle();
      if ($urandom_range(0, 9) == 0) begin
        it = in_item_t'(5'($urandom));
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (run_left[k] == 0) begin
            lv[k] = ~lv[k];
            run_left[k] = (k == 1) ? $urandom_range(1, 5) : press_len(k == 0 ? tap_thr : hold_thr);
          end
          run_left[k]--;
        end
        it = mk(lv[0], lv[1], lv[2], lv[3], $urandom_range(0, 4) != 0);
      end
      send_item(it);
    end
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    result_ch.ready = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    run_done        = 1'b0;
    burst_left      = 0;
    items_sent      = 0;
    settings_used   = 1;
    lv              = '0;
    foreach (run_left[k]) run_left[k] = 0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // toggle mode at reset values: page 3 with source flips, record and bypass taps
    send_item(mk(0, 0, 0, 0, 0));
    send_item(mk(1, 1, 1, 1, 1));
    send_item(mk(1, 0, 1, 1, 1));
    send_item(mk(1, 1, 1, 1, 1));
    send_item(mk(0, 1, 0, 0, 1));
    send_item(mk(0, 1, 0, 0, 1));
    send_item(mk(0, 1, 0, 0, 0));
    send_item(mk(0, 0, 1, 0, 1));
    send_item(mk(0, 0, 0, 0, 1));
    send_item(mk(1, 0, 0, 0, 1));
    send_item(mk(0, 0, 0, 0, 1));

    set_config(1'b1, 4, 3, 5);
    random_phase(100, 4, 3, 1'b1);

    set_config(1'b0, 6, 2, 0);
    random_phase(100, 6, 2, 1'b0);

    // zero thresholds: holds fire on the first tick of a press
    set_config(1'b1, 0, 0, 255);
    send_item(mk(1, 0, 0, 0, 1));
    send_item(mk(1, 1, 1, 0, 1));
    send_item(mk(1, 0, 1, 0, 1));
    send_item(mk(0, 0, 0, 0, 1));
    send_item(mk(0, 0, 1, 0, 1));
    send_item(mk(0, 0, 0, 1, 1));
    send_item(mk(1, 1, 0, 0, 1));
    send_item(mk(0, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 1));
    send_item(mk(0, 0, 0, 0, 1));
    random_phase(80, 0, 0, 1'b0);

    // largest thresholds: bypass and record holds fire at the top count, the
    // shift hold opens page 3 one tick later, and the press counters saturate
    set_config(1'b1, 255, 255, 1);
    send_item(mk(0, 0, 1, 1, 1));
    send_level(mk(1, 0, 1, 1, 1), 259);
    send_level(mk(0, 1, 0, 0, 1), 2);
    send_item(mk(0, 0, 0, 0, 1));
    random_phase(90, 255, 255, 1'b0);

    set_config(1'b0, 12, 1, 94);
    random_phase(100, 12, 1, 1'b0);

    settle();
    run_done <= 1'b1;
    repeat (2) @(negedge clk);
    $display("Drove %0d switch ticks over %0d register settings; compared %0d results,",
             items_sent, settings_used, results_checked);
    $display("  %0d of them carrying a parameter-reset or buffer-clear request.", hold_pulses);
    if (mismatches == 0) begin
      $display("footswitch_tap_hold_panel_unit_tb passed");
    end else begin
      $display("footswitch_tap_hold_panel_unit_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/fthp_pkg.sv
rtl/fthp_if.sv
rtl/fthp_core.sv
rtl/footswitch_tap_hold_panel_unit.sv
tb/sv/fthp_panel_checker.sv
tb/sv/footswitch_tap_hold_panel_unit_tb.sv
